// ----- src/smae_pkg.sv -----
// Shared types, codes and constants of the small matrix arithmetic engine.
package smae_pkg;

  // Default largest matrix side.
  localparam int MAX_DIM_DEF = 8;

  // Fixed field widths.
  localparam int ELEM_W = 16;
  localparam int RES_W  = 35;
  localparam int SIZE_W = 4;
  localparam int MODE_W = 2;

  // Register file geometry.
  localparam int DATA_W = 32;
  localparam int PADDR_W = 5;
  localparam int REG_IDX_W = 3;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_OP_MODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALAR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROWS_A  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COLS_A  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROWS_B  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B  = 3'd5;

  // Operation codes.
  localparam logic [MODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] OP_SUB    = 2'd1;
  localparam logic [MODE_W-1:0] OP_SCALE  = 2'd2;
  localparam logic [MODE_W-1:0] OP_MATMUL = 2'd3;

  // Tag that travels with one operand pair through the multiply-accumulate unit.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

endpackage

// ----- src/small_matrix_arithmetic_engine_core.sv -----
// Top level of the small matrix arithmetic engine with its register file.
// The engine takes signed 16-bit words one per cycle, matrix A then matrix B in
// row-major order, sized by the rows and columns registers, and after the final
// B word streams out the result of add, subtract, scale or matrix product in
// row-major order, last_element set on the final word; a size mismatch gives a
// single word with status set. Loading runs at one word per cycle while the
// result word register is free. Per element the single multiply-accumulate
// unit takes K operand pairs, one per cycle, from the registered memory read
// ports, K being cols_a for the matrix product and 1 otherwise; the sequencer
// waits for the sum to leave the unit before the next element. No clearing pass
// is needed after reset. While an element is computed the input is not ready.
module small_matrix_arithmetic_engine_core
  import smae_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ELEM_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [RES_W-1:0]  out_result_value,
  output logic                     out_status,
  output logic                     out_last_element
);

  logic [MODE_W-1:0]        op_mode_r;
  logic signed [ELEM_W-1:0] scalar_r;
  logic [SIZE_W-1:0]        rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic                     wr_en;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic [DIM_W-1:0]         dim_ra, dim_ca, dim_rb, dim_cb;
  logic                     we_a, we_b;
  logic [ADDR_W-1:0]        waddr, raddr_a, raddr_b;
  logic signed [ELEM_W-1:0] wdata, rdata_a, rdata_b;
  mac_tag_t                 iss_tag;
  logic                     mac_done;
  logic signed [RES_W-1:0]  mac_acc;

  // A size of zero counts as one, a size above the limit as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(v);
    end
    return d;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= OP_ADD;
      scalar_r  <= ELEM_W'(1);
      rows_a_r  <= SIZE_W'(1);
      cols_a_r  <= SIZE_W'(1);
      rows_b_r  <= SIZE_W'(1);
      cols_b_r  <= SIZE_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OP_MODE: op_mode_r <= pwdata[MODE_W-1:0];
        REG_SCALAR:  scalar_r  <= pwdata[ELEM_W-1:0];
        REG_ROWS_A:  rows_a_r  <= pwdata[SIZE_W-1:0];
        REG_COLS_A:  cols_a_r  <= pwdata[SIZE_W-1:0];
        REG_ROWS_B:  rows_b_r  <= pwdata[SIZE_W-1:0];
        REG_COLS_B:  cols_b_r  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_OP_MODE: prdata = DATA_W'(op_mode_r);
      REG_SCALAR:  prdata = DATA_W'(scalar_r);
      REG_ROWS_A:  prdata = DATA_W'(rows_a_r);
      REG_COLS_A:  prdata = DATA_W'(cols_a_r);
      REG_ROWS_B:  prdata = DATA_W'(rows_b_r);
      REG_COLS_B:  prdata = DATA_W'(cols_b_r);
      default:     prdata = '0;
    endcase
  end

  assign dim_ra = clamp_dim(rows_a_r);
  assign dim_ca = clamp_dim(cols_a_r);
  assign dim_rb = clamp_dim(rows_b_r);
  assign dim_cb = clamp_dim(cols_b_r);

  // Sequencer with load counter and result word register.
  smae_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .op_mode          (op_mode_r),
    .dim_ra           (dim_ra),
    .dim_ca           (dim_ca),
    .dim_rb           (dim_rb),
    .dim_cb           (dim_cb),
    .we_a             (we_a),
    .we_b             (we_b),
    .waddr            (waddr),
    .wdata            (wdata),
    .raddr_a          (raddr_a),
    .raddr_b          (raddr_b),
    .iss_tag          (iss_tag),
    .mac_done         (mac_done),
    .mac_acc          (mac_acc),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last_element (out_last_element)
  );

  // Operand memories.
  smae_store #(
    .MAX_DIM (MAX_DIM)
  ) u_store (
    .clk     (clk),
    .we_a    (we_a),
    .we_b    (we_b),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Shared multiply-accumulate unit.
  smae_mac u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_mode      (op_mode_r),
    .scalar_value (scalar_r),
    .iss_tag      (iss_tag),
    .rdata_a      (rdata_a),
    .rdata_b      (rdata_b),
    .done         (mac_done),
    .acc          (mac_acc)
  );

endmodule

// ----- src/smae_store.sv -----
// Operand memories for matrix A and matrix B with registered read data.
module smae_store
  import smae_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we_a,
  input  logic                     we_b,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [ELEM_W-1:0] wdata,
  input  logic [ADDR_W-1:0]        raddr_a,
  input  logic [ADDR_W-1:0]        raddr_b,
  output logic signed [ELEM_W-1:0] rdata_a,
  output logic signed [ELEM_W-1:0] rdata_b
);

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];

  // Matrix A store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    rdata_a <= mem_a[raddr_a];
  end

  // Matrix B store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    rdata_b <= mem_b[raddr_b];
  end

endmodule

// ----- src/smae_mac.sv -----
// Shared arithmetic unit: add, subtract or multiply stage followed by an accumulator.
module smae_mac
  import smae_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [MODE_W-1:0]        op_mode,
  input  logic signed [ELEM_W-1:0] scalar_value,
  input  mac_tag_t                 iss_tag,
  input  logic signed [ELEM_W-1:0] rdata_a,
  input  logic signed [ELEM_W-1:0] rdata_b,
  output logic                     done,
  output logic signed [RES_W-1:0]  acc
);

  mac_tag_t                   tag1_r, tag2_r;
  logic                       done_r;
  logic signed [RES_W-1:0]    term_r, term_nxt;
  logic signed [RES_W-1:0]    acc_r, acc_nxt;
  logic signed [ELEM_W-1:0]   mul_b;
  logic signed [2*ELEM_W-1:0] prod;

  // One multiplier serves both the scalar and the matrix product.
  assign mul_b = (op_mode == OP_SCALE) ? scalar_value : rdata_b;
  assign prod  = rdata_a * mul_b;

  // Term selection by operation.
  always_comb begin
    unique case (op_mode)
      OP_ADD:  term_nxt = RES_W'(rdata_a) + RES_W'(rdata_b);
      OP_SUB:  term_nxt = RES_W'(rdata_a) - RES_W'(rdata_b);
      default: term_nxt = RES_W'(prod);
    endcase
  end

  // The first term of an element restarts the sum.
  assign acc_nxt = tag2_r.first ? term_r : acc_r + term_r;

  // Tag pipeline follows the registered memory read and the term stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      done_r <= 1'b0;
    end else begin
      tag1_r <= iss_tag;
      tag2_r <= tag1_r;
      done_r <= tag2_r.valid && tag2_r.last;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (tag1_r.valid) begin
      term_r <= term_nxt;
    end
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

// ----- src/smae_seq.sv -----
// Sequencer: element loading, size check, index walk and the result word register.
module smae_seq
  import smae_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int DEPTH = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int CNT_W = $clog2(2 * DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic [MODE_W-1:0]        op_mode,
  input  logic [DIM_W-1:0]         dim_ra,
  input  logic [DIM_W-1:0]         dim_ca,
  input  logic [DIM_W-1:0]         dim_rb,
  input  logic [DIM_W-1:0]         dim_cb,
  output logic                     we_a,
  output logic                     we_b,
  output logic [ADDR_W-1:0]        waddr,
  output logic signed [ELEM_W-1:0] wdata,
  output logic [ADDR_W-1:0]        raddr_a,
  output logic [ADDR_W-1:0]        raddr_b,
  output mac_tag_t                 iss_tag,
  input  logic                     mac_done,
  input  logic signed [RES_W-1:0]  mac_acc,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [RES_W-1:0]  out_result_value,
  output logic                     out_status,
  output logic                     out_last_element
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_RUN,
    S_WAIT,
    S_PUT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        load_cnt_r, load_cnt_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic                    elem_last_r, elem_last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0] out_res_r, out_res_nxt;
  logic                    out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    accept, out_free;
  logic [CNT_W-1:0]        na, nb, total, b_off, cnt_inc;
  logic                    in_a, in_b, load_done, mismatch, mode_mm;
  logic [DIM_W-1:0]        nc, kn;
  logic                    k_last, j_last, i_last;
  logic [CNT_W-1:0]        row_base;

  // Load bookkeeping follows the sizes as they stand at each word.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_LOAD) && out_free;
  assign accept    = in_valid && in_ready;
  assign na        = CNT_W'(dim_ra) * CNT_W'(dim_ca);
  assign nb        = CNT_W'(dim_rb) * CNT_W'(dim_cb);
  assign total     = na + nb;
  assign b_off     = load_cnt_r - na;
  assign in_a      = load_cnt_r < na;
  assign in_b      = !in_a && (b_off < nb);
  assign cnt_inc   = load_cnt_r + 1'b1;
  assign load_done = cnt_inc >= total;

  assign we_a  = accept && in_a;
  assign we_b  = accept && in_b;
  assign waddr = in_a ? load_cnt_r[ADDR_W-1:0] : b_off[ADDR_W-1:0];
  assign wdata = in_element_value;

  // Size check for the chosen operation; scaling has none.
  always_comb begin
    unique case (op_mode) inside
      OP_ADD, OP_SUB: mismatch = (dim_ra != dim_rb) || (dim_ca != dim_cb);
      OP_MATMUL:      mismatch = (dim_ca != dim_rb) || (dim_ra != dim_cb);
      default:        mismatch = 1'b0;
    endcase
  end

  // Result shape and inner loop length.
  assign mode_mm = (op_mode == OP_MATMUL);
  assign nc      = mode_mm ? dim_cb : dim_ca;
  assign kn      = mode_mm ? dim_ca : DIM_W'(1);
  assign k_last  = (CNT_W'(k_r) + 1'b1) == CNT_W'(kn);
  assign j_last  = (CNT_W'(j_r) + 1'b1) == CNT_W'(nc);
  assign i_last  = (CNT_W'(i_r) + 1'b1) == CNT_W'(dim_ra);

  // Operand addresses for the current (i, j, k) step.
  assign row_base = CNT_W'(i_r) * CNT_W'(dim_ca);
  assign raddr_a  = ADDR_W'(row_base + (mode_mm ? CNT_W'(k_r) : CNT_W'(j_r)));
  assign raddr_b  = mode_mm ? ADDR_W'(CNT_W'(k_r) * CNT_W'(dim_cb) + CNT_W'(j_r))
                            : ADDR_W'(row_base + CNT_W'(j_r));

  assign iss_tag.valid = (state_r == S_RUN);
  assign iss_tag.first = (k_r == '0);
  assign iss_tag.last  = k_last;

  // Next-state logic.
  always_comb begin
    state_nxt      = state_r;
    load_cnt_nxt   = load_cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    elem_last_nxt  = elem_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_res_nxt    = out_res_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (load_done) begin
            load_cnt_nxt = '0;
            i_nxt        = '0;
            j_nxt        = '0;
            k_nxt        = '0;
            if (mismatch) begin
              out_valid_nxt  = 1'b1;
              out_res_nxt    = '0;
              out_status_nxt = 1'b1;
              out_last_nxt   = 1'b1;
            end else begin
              state_nxt = S_RUN;
            end
          end else begin
            load_cnt_nxt = cnt_inc;
          end
        end
      end
      S_RUN: begin
        if (k_last) begin
          k_nxt         = '0;
          elem_last_nxt = i_last && j_last;
          state_nxt     = S_WAIT;
          if (j_last) begin
            j_nxt = '0;
            if (!i_last) begin
              i_nxt = i_r + 1'b1;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_res_nxt    = mac_acc;
          out_status_nxt = 1'b0;
          out_last_nxt   = elem_last_r;
          state_nxt      = elem_last_r ? S_LOAD : S_RUN;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // State, counters and the result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_cnt_r   <= load_cnt_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      elem_last_r  <= elem_last_nxt;
      out_valid_r  <= out_valid_nxt;
      out_res_r    <= out_res_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_status_r;
  assign out_last_element = out_last_r;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the small matrix arithmetic engine core.
`timescale 1ns / 1ps

module tb;
  import smae_pkg::*;

  localparam int STORE_DEPTH = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD = 300;
  localparam logic [MODE_W-1:0] OP_CODES [4] = '{OP_ADD, OP_SUB, OP_SCALE, OP_MATMUL};

  // One word of the result stream.
  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    status;
    logic                    last;
  } matrix_word_t;

  // Mirror of the engine: register copies, both stores, the load counter and
  // the words still owed by the block.
  class matrix_scoreboard;
    logic [MODE_W-1:0]        op;
    logic signed [ELEM_W-1:0] factor;
    logic [SIZE_W-1:0]        rows_a, cols_a, rows_b, cols_b;
    logic signed [ELEM_W-1:0] a_mem [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_mem [STORE_DEPTH];
    int                       loaded;
    matrix_word_t             owed_words [$];
    int                       mismatches, words_seen, elements_seen;
    int                       products_done, size_faults;

    function new();
      op = OP_ADD;
      factor = 1;
      rows_a = 1;
      cols_a = 1;
      rows_b = 1;
      cols_b = 1;
      loaded = 0;
      foreach (a_mem[i]) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
      end
    endfunction

    // A side of zero counts as one; anything past the largest side is capped.
    function int clamp_side(logic [SIZE_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM_DEF) return MAX_DIM_DEF;
      return raw;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_OP_MODE: op = data[MODE_W-1:0];
        REG_SCALAR:  factor = data[ELEM_W-1:0];
        REG_ROWS_A:  rows_a = data[SIZE_W-1:0];
        REG_COLS_A:  cols_a = data[SIZE_W-1:0];
        REG_ROWS_B:  rows_b = data[SIZE_W-1:0];
        REG_COLS_B:  cols_b = data[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // Store one accepted word; when the load completes, queue the whole result.
    function void take_element(logic signed [ELEM_W-1:0] elem);
      int ra, ca, rb, cb, na, nb, nr, nc, i, j, k;
      longint acc;
      matrix_word_t w;
      ra = clamp_side(rows_a);
      ca = clamp_side(cols_a);
      rb = clamp_side(rows_b);
      cb = clamp_side(cols_b);
      na = ra * ca;
      nb = rb * cb;
      elements_seen++;
      if (loaded < na) a_mem[loaded] = elem;
      else if (loaded - na < nb) b_mem[loaded - na] = elem;
      loaded++;
      if (loaded < na + nb) return;
      loaded = 0;
      products_done++;

      // Size check: add and subtract need equal shapes, the product needs
      // transposed shapes, scaling makes no check.
      if (((op == OP_ADD || op == OP_SUB) && (ra != rb || ca != cb)) ||
          (op == OP_MATMUL && (ca != rb || ra != cb))) begin
        w.value = '0;
        w.status = 1'b1;
        w.last = 1'b1;
        owed_words.push_back(w);
        size_faults++;
        return;
      end

      nr = ra;
      nc = (op == OP_MATMUL) ? cb : ca;
      for (i = 0; i < nr; i++) begin
        for (j = 0; j < nc; j++) begin
          acc = 0;
          case (op)
            OP_ADD:   acc = longint'(a_mem[i*ca+j]) + longint'(b_mem[i*ca+j]);
            OP_SUB:   acc = longint'(a_mem[i*ca+j]) - longint'(b_mem[i*ca+j]);
            OP_SCALE: acc = longint'(a_mem[i*ca+j]) * longint'(factor);
            default: begin
              for (k = 0; k < ca; k++)
                acc += longint'(a_mem[i*ca+k]) * longint'(b_mem[k*cb+j]);
            end
          endcase
          w.value = acc[RES_W-1:0];
          w.status = 1'b0;
          w.last = (i == nr - 1) && (j == nc - 1);
          owed_words.push_back(w);
        end
      end
    endfunction

    // Compare one accepted result word with the oldest owed word.
    function void check_word(logic signed [RES_W-1:0] value, logic status, logic last);
      matrix_word_t w;
      words_seen++;
      if (owed_words.size() == 0) begin
        $error("Unexpected result word: value %0d status %0b last %0b", value, status, last);
        mismatches++;
        return;
      end
      w = owed_words.pop_front();
      if (value !== w.value) begin
        $error("result_value: expected %0d, got %0d", w.value, value);
        mismatches++;
      end
      if (status !== w.status) begin
        $error("status: expected %0b, got %0b", w.status, status);
        mismatches++;
      end
      if (last !== w.last) begin
        $error("last_element: expected %0b, got %0b", w.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     psel, penable, pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]        pwdata, prdata;
  logic                     pready;
  logic                     in_valid, in_ready;
  logic signed [ELEM_W-1:0] in_element_value;
  logic                     out_valid, out_ready;
  logic signed [RES_W-1:0]  out_result_value;
  logic                     out_status, out_last_element;

  bit                       steady = 1'b0;
  bit                       hold_req = 1'b0;
  int                       cycle_count = 0;
  int                       random_items = 0;
  matrix_scoreboard         sb = new();

  small_matrix_arithmetic_engine_core dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_element_value,
    .out_valid, .out_ready, .out_result_value, .out_status, .out_last_element
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Register write: setup phase, access phase, then the bus goes idle.
  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [MODE_W-1:0] mode, logic signed [ELEM_W-1:0] scale,
                           logic [SIZE_W-1:0] ra, logic [SIZE_W-1:0] ca,
                           logic [SIZE_W-1:0] rb, logic [SIZE_W-1:0] cb);
    apb_write(REG_OP_MODE, DATA_W'(mode));
    apb_write(REG_SCALAR, DATA_W'(scale));
    apb_write(REG_ROWS_A, DATA_W'(ra));
    apb_write(REG_COLS_A, DATA_W'(ca));
    apb_write(REG_ROWS_B, DATA_W'(rb));
    apb_write(REG_COLS_B, DATA_W'(cb));
  endtask

  // Offer one word after a random gap; valid stays high when the gap is zero.
  task automatic send_element(logic signed [ELEM_W-1:0] elem);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= elem;
    do @(posedge clk); while (!in_ready);
    sb.take_element(elem);
  endtask

  // Stop offering, wait for every owed word, then let the engine go quiet.
  task automatic close_phase();
    in_valid <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_case(logic [MODE_W-1:0] mode, logic signed [ELEM_W-1:0] scale,
                          logic [SIZE_W-1:0] ra, logic [SIZE_W-1:0] ca,
                          logic [SIZE_W-1:0] rb, logic [SIZE_W-1:0] cb,
                          logic signed [ELEM_W-1:0] words [$]);
    configure(mode, scale, ra, ca, rb, cb);
    foreach (words[i]) send_element(words[i]);
    close_phase();
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3: return -16'sd1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Mostly small sides, now and then a large one.
  function automatic int pick_side();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 8);
    return $urandom_range(1, 4);
  endfunction

  // Register value for a side, sometimes using a value that gets clamped.
  function automatic logic [SIZE_W-1:0] raw_side(int side);
    if (side == 1 && $urandom_range(0, 3) == 0) return '0;
    if (side == MAX_DIM_DEF && $urandom_range(0, 1) == 0) return SIZE_W'($urandom_range(9, 15));
    return SIZE_W'(side);
  endfunction

  // One random computation; most have shapes that suit the operation.
  task automatic run_random();
    int ra, ca, rb, cb;
    logic [MODE_W-1:0] mode;
    mode = OP_CODES[$urandom_range(0, 3)];
    ra = pick_side();
    ca = pick_side();
    if ($urandom_range(0, 4) == 0) begin
      rb = pick_side();
      cb = pick_side();
    end else if (mode == OP_MATMUL) begin
      rb = ca;
      cb = ra;
    end else begin
      rb = ra;
      cb = ca;
    end
    configure(mode, rand_scale(), raw_side(ra), raw_side(ca), raw_side(rb), raw_side(cb));
    steady = ($urandom_range(0, 3) == 0);
    repeat (ra * ca + rb * cb) send_element(rand_elem());
    random_items += ra * ca + rb * cb;
    close_phase();
    steady = 1'b0;
  endtask

  // Result side: random stalls per word, one long hold-off to back the engine up.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 12);
      if (!held && hold_req) begin
        stall = LONG_HOLD;
        held = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_word(out_result_value, out_status, out_last_element);
    end
  end

  // Main sequence: reset, directed cases, random computations, mid-load changes.
  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_element_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings give a 1x1 add of the largest values.
    send_element(16'sd32767);
    send_element(16'sd32767);
    close_phase();

    run_case(OP_SUB, 16'sd1, 1, 1, 1, 1, '{-16'sd32768, 16'sd32767});
    // Scaling uses no B values and no shape check; zero sides count as one.
    run_case(OP_SCALE, -16'sd32768, 0, 2, 0, 0,
             '{-16'sd32768, 16'sd32767, 16'sh5555});
    run_case(OP_MATMUL, 16'sd1, 2, 3, 3, 2,
             '{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd1, 16'sd0,
               -16'sd32768, 16'sd32767, -16'sd32768, 16'sd1, -16'sd32768, -16'sd32767});
    // Shape mismatches give a single error word.
    run_case(OP_ADD, 16'sd1, 1, 1, 1, 2, '{16'sd5, -16'sd6, 16'sd7});
    run_case(OP_MATMUL, 16'sd1, 1, 2, 1, 1, '{16'sd3, 16'sd4, -16'sd2});

    // Back-to-back 1x1 loads while the result side holds off for a long time:
    // the result register stays full and the engine stops taking words.
    configure(OP_ADD, 16'sd1, 1, 1, 1, 1);
    hold_req = 1'b1;
    repeat (8) send_element(rand_elem());
    close_phase();

    while (random_items < 50) run_random();

    // Sides grow while a load is partly done.
    configure(OP_ADD, 16'sd1, 2, 2, 2, 2);
    repeat (3) send_element(rand_elem());
    close_phase();
    apb_write(REG_ROWS_A, 3);
    apb_write(REG_ROWS_B, 3);
    repeat (9) send_element(rand_elem());
    close_phase();

    // Sides shrink below the count already loaded: the next word ends the load.
    configure(OP_MATMUL, 16'sd1, 2, 2, 2, 2);
    repeat (5) send_element(rand_elem());
    close_phase();
    configure(OP_MATMUL, 16'sd1, 1, 1, 1, 1);
    send_element(rand_elem());
    close_phase();

    $display("Loaded %0d words into %0d computations, %0d of them with mismatched shapes.",
             sb.elements_seen, sb.products_done, sb.size_faults);
    $display("Checked %0d result words under random gaps, stalls and one long hold-off.",
             sb.words_seen);
    if (sb.mismatches == 0 && sb.owed_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/smae_pkg.sv
src/smae_store.sv
src/smae_mac.sv
src/smae_seq.sv
src/small_matrix_arithmetic_engine_core.sv
dv/tb.sv
